>>> rtl/cfws_pkg.sv
// ----------------------------------------------------------------------------
// cfws_pkg
// Types, register indexes and constants shared by the converter supervisor.
// ----------------------------------------------------------------------------
package cfws_pkg;

  localparam int unsigned VoltW   = 14;
  localparam int unsigned CurrW   = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  // Boost phases in which the bus warning is armed
  localparam logic [3:0] BoostPhaseBusA = 4'd2;
  localparam logic [3:0] BoostPhaseBusB = 4'd3;

  // Fault and warning bit positions
  localparam int unsigned FltDclinkOv = 0;
  localparam int unsigned FltCellOc   = 1;
  localparam int unsigned FltCellOv   = 2;
  localparam int unsigned FltCellUv   = 3;
  localparam int unsigned WrnCellUv   = 0;
  localparam int unsigned WrnDclinkUv = 1;
  localparam int unsigned WrnBusErr   = 2;
  localparam int unsigned WrnFanStop  = 3;

  typedef enum logic [2:0] {
    MODE_PWM   = 3'd0,
    MODE_10MS  = 3'd1,
    MODE_100MS = 3'd2,
    MODE_1S    = 3'd3,
    MODE_FAN   = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DCLINK_OV    = 3'd0,
    REG_CELL_OC      = 3'd1,
    REG_CELL_OV      = 3'd2,
    REG_CELL_UV      = 3'd3,
    REG_DCLINK_UV    = 3'd4,
    REG_BUS_ERR_LIM  = 3'd5,
    REG_BUS_MIN_DCLK = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [VoltW-1:0]  dclink_over_volt_limit;
    logic [CurrW-1:0]  cell_over_current_limit;
    logic [VoltW-1:0]  cell_over_volt_limit;
    logic [VoltW-1:0]  cell_under_volt_limit;
    logic [VoltW-1:0]  dclink_under_volt_limit;
    logic [CountW-1:0] bus_error_limit;
    logic [VoltW-1:0]  bus_warn_min_dclink;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    dclink_over_volt_limit:  14'd8000,
    cell_over_current_limit: 16'd5000,
    cell_over_volt_limit:    14'd900,
    cell_under_volt_limit:   14'd440,
    dclink_under_volt_limit: 14'd3000,
    bus_error_limit:         16'd50,
    bus_warn_min_dclink:     14'd3400
  };

  typedef struct packed {
    mode_e            mode;
    logic             clear_request;
    logic [VoltW-1:0] dclink_volt_avg;
    logic [CurrW-1:0] cell_current_filtered;
    logic [VoltW-1:0] cell_volt_avg;
    logic [VoltW-1:0] cell_volt_now;
    logic [VoltW-1:0] dclink_volt_now;
    logic             boost_running;
    logic [3:0]       boost_phase;
    logic [2:0]       bus_last_error;
    logic             inverter_sequence_ok;
  } item_t;

  typedef struct packed {
    logic [3:0] fault_bits;
    logic       fault_active;
    logic [3:0] warn_bits;
    logic       warn_active;
    logic       converter_ready;
  } result_t;

endpackage

>>> rtl/cfws_if.sv
// ----------------------------------------------------------------------------
// cfws_if
// Channel interfaces of the converter supervisor: item in, result out, config.
// ----------------------------------------------------------------------------
interface cfws_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        clear_request;
  logic [13:0] dclink_volt_avg;
  logic signed [15:0] cell_current_filtered;
  logic [13:0] cell_volt_avg;
  logic [13:0] cell_volt_now;
  logic [13:0] dclink_volt_now;
  logic        boost_running;
  logic [3:0]  boost_phase;
  logic [2:0]  bus_last_error;
  logic        inverter_sequence_ok;

  modport source (
    output valid, mode, clear_request, dclink_volt_avg, cell_current_filtered,
           cell_volt_avg, cell_volt_now, dclink_volt_now, boost_running,
           boost_phase, bus_last_error, inverter_sequence_ok,
    input  ready
  );
  modport sink (
    input  valid, mode, clear_request, dclink_volt_avg, cell_current_filtered,
           cell_volt_avg, cell_volt_now, dclink_volt_now, boost_running,
           boost_phase, bus_last_error, inverter_sequence_ok,
    output ready
  );
endinterface

interface cfws_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] fault_bits;
  logic       fault_active;
  logic [3:0] warn_bits;
  logic       warn_active;
  logic       converter_ready;

  modport source (
    output valid, fault_bits, fault_active, warn_bits, warn_active, converter_ready,
    input  ready
  );
  modport sink (
    input  valid, fault_bits, fault_active, warn_bits, warn_active, converter_ready,
    output ready
  );
endinterface

interface cfws_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cfws_cfg.sv
// ----------------------------------------------------------------------------
// cfws_cfg
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module cfws_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfws_cfg_if.sink      cfg_i,
  output cfws_pkg::cfg_t cfg_o
);

  cfws_pkg::cfg_t      cfg_q, cfg_d;
  cfws_pkg::reg_idx_e  idx;

  assign cfg_i.ready = 1'b1;
  assign idx         = cfws_pkg::reg_idx_e'(cfg_i.index);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (idx)
        cfws_pkg::REG_DCLINK_OV:    cfg_d.dclink_over_volt_limit  = cfg_i.data[13:0];
        cfws_pkg::REG_CELL_OC:      cfg_d.cell_over_current_limit = cfg_i.data;
        cfws_pkg::REG_CELL_OV:      cfg_d.cell_over_volt_limit    = cfg_i.data[13:0];
        cfws_pkg::REG_CELL_UV:      cfg_d.cell_under_volt_limit   = cfg_i.data[13:0];
        cfws_pkg::REG_DCLINK_UV:    cfg_d.dclink_under_volt_limit = cfg_i.data[13:0];
        cfws_pkg::REG_BUS_ERR_LIM:  cfg_d.bus_error_limit         = cfg_i.data;
        cfws_pkg::REG_BUS_MIN_DCLK: cfg_d.bus_warn_min_dclink     = cfg_i.data[13:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfws_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/cfws_core.sv
// ----------------------------------------------------------------------------
// cfws_core
// Fault latches, warning word and per-second counters; one event per advance.
// ----------------------------------------------------------------------------
module cfws_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  cfws_pkg::item_t   item_i,
  input  cfws_pkg::cfg_t    cfg_i,
  output cfws_pkg::result_t result_o
);

  logic [3:0]                  fault_q, fault_d;
  logic                        fault_sum_q, fault_sum_d;
  logic [3:0]                  warn_q, warn_d;
  logic                        warn_sum_q, warn_sum_d;
  logic                        ready_q, ready_d;
  logic [cfws_pkg::CountW-1:0] bus_cnt_q, bus_cnt_d;
  logic [cfws_pkg::CountW-1:0] fan_cnt_q, fan_cnt_d;
  logic [3:0]                  warn_w;
  logic                        bus_phase_ok;

  assign bus_phase_ok = (item_i.boost_phase == cfws_pkg::BoostPhaseBusA) ||
                        (item_i.boost_phase == cfws_pkg::BoostPhaseBusB);

  always_comb begin
    fault_d     = fault_q;
    fault_sum_d = fault_sum_q;
    warn_d      = warn_q;
    warn_sum_d  = warn_sum_q;
    ready_d     = ready_q;
    bus_cnt_d   = bus_cnt_q;
    fan_cnt_d   = fan_cnt_q;
    warn_w      = '0;
    unique case (item_i.mode)
      cfws_pkg::MODE_PWM: begin
        if (item_i.clear_request) begin
          fault_d = '0;
        end
        if (item_i.dclink_volt_avg > cfg_i.dclink_over_volt_limit) begin
          fault_d[cfws_pkg::FltDclinkOv] = 1'b1;
        end
        if ($signed(item_i.cell_current_filtered) >
            $signed(cfg_i.cell_over_current_limit)) begin
          fault_d[cfws_pkg::FltCellOc] = 1'b1;
        end
        fault_sum_d = |fault_d;
        ready_d     = (fault_d == '0) && !warn_q[cfws_pkg::WrnCellUv] &&
                      item_i.inverter_sequence_ok;
      end
      cfws_pkg::MODE_10MS: begin
        if ((item_i.bus_last_error != '0) && (bus_cnt_q != cfws_pkg::CountMax)) begin
          bus_cnt_d = bus_cnt_q + 1'b1;
        end
      end
      cfws_pkg::MODE_100MS: begin
        if (item_i.cell_volt_avg > cfg_i.cell_over_volt_limit) begin
          fault_d[cfws_pkg::FltCellOv] = 1'b1;
        end
        if ((item_i.cell_volt_avg < cfg_i.cell_under_volt_limit) && item_i.boost_running) begin
          fault_d[cfws_pkg::FltCellUv] = 1'b1;
        end
      end
      cfws_pkg::MODE_1S: begin
        warn_w[cfws_pkg::WrnCellUv] = item_i.cell_volt_now < cfg_i.cell_under_volt_limit;
        warn_w[cfws_pkg::WrnDclinkUv] =
          (item_i.dclink_volt_now < cfg_i.dclink_under_volt_limit) && item_i.boost_running;
        warn_w[cfws_pkg::WrnBusErr] = (bus_cnt_q > cfg_i.bus_error_limit) && bus_phase_ok &&
                                      (item_i.dclink_volt_avg > cfg_i.bus_warn_min_dclink);
        warn_w[cfws_pkg::WrnFanStop] = (fan_cnt_q == '0);
        // restart both per-second counts
        bus_cnt_d  = '0;
        fan_cnt_d  = '0;
        warn_d     = warn_w;
        warn_sum_d = |warn_w;
      end
      cfws_pkg::MODE_FAN: begin
        if (fan_cnt_q != cfws_pkg::CountMax) begin
          fan_cnt_d = fan_cnt_q + 1'b1;
        end
      end
      default: ; // unused modes hold the state
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q     <= '0;
      fault_sum_q <= 1'b0;
      warn_q      <= '0;
      warn_sum_q  <= 1'b0;
      ready_q     <= 1'b0;
      bus_cnt_q   <= '0;
      fan_cnt_q   <= '0;
    end else if (advance_i) begin
      fault_q     <= fault_d;
      fault_sum_q <= fault_sum_d;
      warn_q      <= warn_d;
      warn_sum_q  <= warn_sum_d;
      ready_q     <= ready_d;
      bus_cnt_q   <= bus_cnt_d;
      fan_cnt_q   <= fan_cnt_d;
    end
  end

  assign result_o.fault_bits      = fault_d;
  assign result_o.fault_active    = fault_sum_d;
  assign result_o.warn_bits       = warn_d;
  assign result_o.warn_active     = warn_sum_d;
  assign result_o.converter_ready = ready_d;

endmodule

>>> rtl/converter_fault_warning_supervisor.sv
// ----------------------------------------------------------------------------
// converter_fault_warning_supervisor
// Fault and warning supervisor for a fuel-cell DC-DC converter.
//
//   Channel  Direction  Handshake          Carries
//   in_i     sink       valid / ready      event mode, clear request, measurements
//   out_o    source     valid / ready      fault bits, warning bits, summary flags
//   cfg_i    sink       valid / ready=1    register index, write data
//
// Each event yields one result: the input register holds the event while the
// state update is evaluated, then the result register holds the result.
// Sustained rate is one event per cycle while out_o takes results. Reset clears
// all latches and counters and loads the default thresholds. A stalled result
// register holds the input register; in_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
module converter_fault_warning_supervisor (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfws_in_if.sink   in_i,
  cfws_out_if.source out_o,
  cfws_cfg_if.sink  cfg_i
);

  cfws_pkg::cfg_t    cfg;
  cfws_pkg::item_t   item_q, item_d;
  cfws_pkg::result_t res_q, res_d;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_take;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  assign item_d.mode                  = cfws_pkg::mode_e'(in_i.mode);
  assign item_d.clear_request         = in_i.clear_request;
  assign item_d.dclink_volt_avg       = in_i.dclink_volt_avg;
  assign item_d.cell_current_filtered = in_i.cell_current_filtered;
  assign item_d.cell_volt_avg         = in_i.cell_volt_avg;
  assign item_d.cell_volt_now         = in_i.cell_volt_now;
  assign item_d.dclink_volt_now       = in_i.dclink_volt_now;
  assign item_d.boost_running         = in_i.boost_running;
  assign item_d.boost_phase           = in_i.boost_phase;
  assign item_d.bus_last_error        = in_i.bus_last_error;
  assign item_d.inverter_sequence_ok  = in_i.inverter_sequence_ok;

  cfws_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cfws_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.fault_bits      = res_q.fault_bits;
  assign out_o.fault_active    = res_q.fault_active;
  assign out_o.warn_bits       = res_q.warn_bits;
  assign out_o.warn_active     = res_q.warn_active;
  assign out_o.converter_ready = res_q.converter_ready;

endmodule

>>> sim/supervisor_status_checker.sv
// ----------------------------------------------------------------------------
// supervisor_status_checker
// Watches the event, status and limit channels of the converter supervisor,
// keeps its own copy of the fault, warning and counter state, and compares
// every status transaction against the status that the accepted events imply.
// ----------------------------------------------------------------------------
module supervisor_status_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfws_in_if          ev_i,
  cfws_out_if         st_i,
  cfws_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  cfws_pkg::cfg_t              limits;
  logic [3:0]                  fault_latch_q;
  logic                        fault_sum_q;
  logic [3:0]                  warn_latch_q;
  logic                        warn_sum_q;
  logic                        ready_q;
  logic [cfws_pkg::CountW-1:0] bus_err_cnt_q;
  logic [cfws_pkg::CountW-1:0] fan_cnt_q;
  cfws_pkg::result_t           expected_status_q[$];
  cfws_pkg::result_t           want;
  cfws_pkg::result_t           got;

  task automatic report_mismatch(input string what, input logic [15:0] seen,
                                 input logic [15:0] wanted);
    fail_count_o++;
    $display("mismatch %s: got %0h, expected %0h at %0t", what, seen, wanted, $time);
  endtask

  task automatic check_field(input string what, input logic [3:0] seen,
                             input logic [3:0] wanted);
    if (seen !== wanted) begin
      report_mismatch(what, {12'd0, seen}, {12'd0, wanted});
    end
  endtask

  task automatic load_limit();
    case (cfg_i.index)
      cfws_pkg::REG_DCLINK_OV:
        limits.dclink_over_volt_limit  = cfg_i.data[cfws_pkg::VoltW-1:0];
      cfws_pkg::REG_CELL_OC:
        limits.cell_over_current_limit = cfg_i.data[cfws_pkg::CurrW-1:0];
      cfws_pkg::REG_CELL_OV:
        limits.cell_over_volt_limit    = cfg_i.data[cfws_pkg::VoltW-1:0];
      cfws_pkg::REG_CELL_UV:
        limits.cell_under_volt_limit   = cfg_i.data[cfws_pkg::VoltW-1:0];
      cfws_pkg::REG_DCLINK_UV:
        limits.dclink_under_volt_limit = cfg_i.data[cfws_pkg::VoltW-1:0];
      cfws_pkg::REG_BUS_ERR_LIM:
        limits.bus_error_limit         = cfg_i.data[cfws_pkg::CountW-1:0];
      cfws_pkg::REG_BUS_MIN_DCLK:
        limits.bus_warn_min_dclink     = cfg_i.data[cfws_pkg::VoltW-1:0];
      default: ;
    endcase
  endtask

  // Advance the supervisor state by one event and return the status after it
  task automatic step_supervisor(output cfws_pkg::result_t status);
    logic [3:0] w;
    w = '0;
    case (ev_i.mode)
      cfws_pkg::MODE_PWM: begin
        if (ev_i.clear_request) begin
          fault_latch_q = '0;
          fault_sum_q   = 1'b0;
        end
        if (ev_i.dclink_volt_avg > limits.dclink_over_volt_limit) begin
          fault_latch_q[cfws_pkg::FltDclinkOv] = 1'b1;
        end
        if ($signed(ev_i.cell_current_filtered) > $signed(limits.cell_over_current_limit)) begin
          fault_latch_q[cfws_pkg::FltCellOc] = 1'b1;
        end
        fault_sum_q = |fault_latch_q;
        ready_q = (fault_latch_q == '0) && !warn_latch_q[cfws_pkg::WrnCellUv] &&
                  ev_i.inverter_sequence_ok;
      end
      cfws_pkg::MODE_10MS: begin
        if (ev_i.bus_last_error != '0 && bus_err_cnt_q != cfws_pkg::CountMax) begin
          bus_err_cnt_q = bus_err_cnt_q + 1'b1;
        end
      end
      cfws_pkg::MODE_100MS: begin
        if (ev_i.cell_volt_avg > limits.cell_over_volt_limit) begin
          fault_latch_q[cfws_pkg::FltCellOv] = 1'b1;
        end
        if (ev_i.cell_volt_avg < limits.cell_under_volt_limit && ev_i.boost_running) begin
          fault_latch_q[cfws_pkg::FltCellUv] = 1'b1;
        end
      end
      cfws_pkg::MODE_1S: begin
        if (ev_i.cell_volt_now < limits.cell_under_volt_limit) begin
          w[cfws_pkg::WrnCellUv] = 1'b1;
        end
        if (ev_i.dclink_volt_now < limits.dclink_under_volt_limit && ev_i.boost_running) begin
          w[cfws_pkg::WrnDclinkUv] = 1'b1;
        end
        if (bus_err_cnt_q > limits.bus_error_limit &&
            (ev_i.boost_phase == cfws_pkg::BoostPhaseBusA ||
             ev_i.boost_phase == cfws_pkg::BoostPhaseBusB) &&
            ev_i.dclink_volt_avg > limits.bus_warn_min_dclink) begin
          w[cfws_pkg::WrnBusErr] = 1'b1;
        end
        bus_err_cnt_q = '0;
        // no pulses this second: flag the fan, otherwise restart the count
        if (fan_cnt_q == '0) w[cfws_pkg::WrnFanStop] = 1'b1;
        else fan_cnt_q = '0;
        warn_latch_q = w;
        warn_sum_q   = |w;
      end
      cfws_pkg::MODE_FAN: begin
        if (fan_cnt_q != cfws_pkg::CountMax) fan_cnt_q = fan_cnt_q + 1'b1;
      end
      default: ;
    endcase
    status = '{fault_latch_q, fault_sum_q, warn_latch_q, warn_sum_q, ready_q};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits        = cfws_pkg::CfgReset;
      fault_latch_q = '0;
      fault_sum_q   = 1'b0;
      warn_latch_q  = '0;
      warn_sum_q    = 1'b0;
      ready_q       = 1'b0;
      bus_err_cnt_q = '0;
      fan_cnt_q     = '0;
      expected_status_q.delete();
      pending_o     = 0;
      fail_count_o  = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) load_limit();
      if (st_i.valid && st_i.ready) begin
        got = '{st_i.fault_bits, st_i.fault_active, st_i.warn_bits, st_i.warn_active,
                st_i.converter_ready};
        if (expected_status_q.size() == 0) begin
          report_mismatch("status with no event pending", {5'd0, got}, 16'd0);
        end else begin
          want = expected_status_q.pop_front();
          check_field("fault_bits", got.fault_bits, want.fault_bits);
          check_field("fault_active", {3'd0, got.fault_active}, {3'd0, want.fault_active});
          check_field("warn_bits", got.warn_bits, want.warn_bits);
          check_field("warn_active", {3'd0, got.warn_active}, {3'd0, want.warn_active});
          check_field("converter_ready", {3'd0, got.converter_ready},
                      {3'd0, want.converter_ready});
        end
      end
      if (ev_i.valid && ev_i.ready) begin
        step_supervisor(want);
        expected_status_q.push_back(want);
      end
      pending_o = expected_status_q.size();
    end
  end

endmodule

>>> sim/tb_converter_fault_warning_supervisor.sv
// ----------------------------------------------------------------------------
// tb_converter_fault_warning_supervisor
// Drives ticks, fan pulses and limit writes into the converter supervisor:
// directed corner events, then randomized one-second sequences under several
// limit settings with bursty input and a stalling status sink. The checker
// beside the block scores every status transaction.
// ----------------------------------------------------------------------------
module tb_converter_fault_warning_supervisor;

  localparam int unsigned ResetCycles     = 12;
  localparam int unsigned RandomItems     = 1150;
  localparam int unsigned RandomPhases    = 6;
  localparam int unsigned HoldOffCycles   = 300;
  localparam int unsigned HoldOffPhase    = 3;
  localparam int unsigned QuietLimit      = 2000;
  localparam int unsigned DrainCycles     = 8;
  localparam int unsigned ModeFirstUnused = 5;
  localparam int unsigned ModeLast        = 7;
  localparam int          VoltMax         = (1 << cfws_pkg::VoltW) - 1;

  typedef enum int unsigned {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic               clear_request;
    logic [13:0]        dclink_volt_avg;
    logic signed [15:0] cell_current_filtered;
    logic [13:0]        cell_volt_avg;
    logic [13:0]        cell_volt_now;
    logic [13:0]        dclink_volt_now;
    logic               boost_running;
    logic [3:0]         boost_phase;
    logic [2:0]         bus_last_error;
    logic               inverter_sequence_ok;
  } sup_event_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  int unsigned    fail_count;
  int unsigned    pending;
  cfws_pkg::cfg_t lim;
  bit             tx_gappy;
  int unsigned    burst_left;
  rx_style_e      rx_style;
  bit             hold_off_req;

  cfws_in_if  ev_if ();
  cfws_out_if st_if ();
  cfws_cfg_if cfg_if ();

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  converter_fault_warning_supervisor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (st_if),
    .cfg_i  (cfg_if)
  );

  supervisor_status_checker u_status_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_i         (ev_if),
    .st_i         (st_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [13:0] volt_near(input logic [13:0] limit);
    int v;
    if ($urandom_range(0, 2) == 0) return 14'($urandom);
    v = int'(limit) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > VoltMax) v = VoltMax;
    return 14'(v);
  endfunction

  function automatic logic signed [15:0] current_near(input logic [15:0] limit);
    int v;
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    v = int'($signed(limit)) + int'($urandom_range(0, 6)) - 3;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Keep measurements close to the active limits so compares land on both sides
  function automatic sup_event_t random_event(input logic [2:0] mode);
    sup_event_t e;
    e.mode                  = mode;
    e.clear_request         = ($urandom_range(0, 3) == 0);
    e.dclink_volt_avg       = volt_near($urandom_range(0, 1) ? lim.dclink_over_volt_limit
                                                            : lim.bus_warn_min_dclink);
    e.cell_current_filtered = current_near(lim.cell_over_current_limit);
    e.cell_volt_avg         = volt_near($urandom_range(0, 1) ? lim.cell_over_volt_limit
                                                            : lim.cell_under_volt_limit);
    e.cell_volt_now         = volt_near(lim.cell_under_volt_limit);
    e.dclink_volt_now       = volt_near(lim.dclink_under_volt_limit);
    e.boost_running         = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      e.boost_phase = $urandom_range(0, 1) ? cfws_pkg::BoostPhaseBusA
                                           : cfws_pkg::BoostPhaseBusB;
    end else begin
      e.boost_phase = 4'($urandom);
    end
    e.bus_last_error        = ($urandom_range(0, 4) < 2) ? 3'd0 : 3'($urandom_range(1, 7));
    e.inverter_sequence_ok  = ($urandom_range(0, 4) != 0);
    return e;
  endfunction

  function automatic logic [2:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return cfws_pkg::MODE_PWM;
    else if (r < 65) return cfws_pkg::MODE_10MS;
    else if (r < 77) return cfws_pkg::MODE_100MS;
    else if (r < 92) return cfws_pkg::MODE_FAN;
    else if (r < 96) return cfws_pkg::MODE_1S;
    else return 3'($urandom_range(ModeFirstUnused, ModeLast));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic drive_event(input sup_event_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gappy) begin
        gap = $urandom_range(1, 6);
        ev_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    ev_if.valid                 <= 1'b1;
    ev_if.mode                  <= e.mode;
    ev_if.clear_request         <= e.clear_request;
    ev_if.dclink_volt_avg       <= e.dclink_volt_avg;
    ev_if.cell_current_filtered <= e.cell_current_filtered;
    ev_if.cell_volt_avg         <= e.cell_volt_avg;
    ev_if.cell_volt_now         <= e.cell_volt_now;
    ev_if.dclink_volt_now       <= e.dclink_volt_now;
    ev_if.boost_running         <= e.boost_running;
    ev_if.boost_phase           <= e.boost_phase;
    ev_if.bus_last_error        <= e.bus_last_error;
    ev_if.inverter_sequence_ok  <= e.inverter_sequence_ok;
    do @(posedge clk_i); while (!ev_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [2:0] mode, input logic clr,
                             input logic [13:0] dca, input logic signed [15:0] cur,
                             input logic [13:0] cva, input logic [13:0] cvn,
                             input logic [13:0] dcn, input logic boost,
                             input logic [3:0] phase, input logic [2:0] err,
                             input logic inv);
    sup_event_t e;
    e = '{mode, clr, dca, cur, cva, cvn, dcn, boost, phase, err, inv};
    drive_event(e);
  endtask

  task automatic write_reg(input cfws_pkg::reg_idx_e idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  // Upper data bits of the 14-bit limits are random: the block must drop them
  task automatic load_limits();
    write_reg(cfws_pkg::REG_DCLINK_OV, {2'($urandom), lim.dclink_over_volt_limit});
    write_reg(cfws_pkg::REG_CELL_OC, lim.cell_over_current_limit);
    write_reg(cfws_pkg::REG_CELL_OV, {2'($urandom), lim.cell_over_volt_limit});
    write_reg(cfws_pkg::REG_CELL_UV, {2'($urandom), lim.cell_under_volt_limit});
    write_reg(cfws_pkg::REG_DCLINK_UV, {2'($urandom), lim.dclink_under_volt_limit});
    write_reg(cfws_pkg::REG_BUS_ERR_LIM, lim.bus_error_limit);
    write_reg(cfws_pkg::REG_BUS_MIN_DCLK, {2'($urandom), lim.bus_warn_min_dclink});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic pick_limits(input int unsigned phase);
    case (phase)
      0: begin
        lim = cfws_pkg::CfgReset;
        lim.bus_error_limit = 16'($urandom_range(0, 6));
      end
      1: begin
        lim = '0;
        lim.cell_over_current_limit = 16'h8000;
      end
      2: begin
        lim.dclink_over_volt_limit  = '1;
        lim.cell_over_current_limit = 16'h7FFF;
        lim.cell_over_volt_limit    = '1;
        lim.cell_under_volt_limit   = '1;
        lim.dclink_under_volt_limit = '1;
        lim.bus_error_limit         = '1;
        lim.bus_warn_min_dclink     = '1;
      end
      default: begin
        lim.dclink_over_volt_limit  = 14'($urandom);
        lim.cell_over_current_limit = 16'($urandom);
        lim.cell_over_volt_limit    = 14'($urandom);
        lim.cell_under_volt_limit   = 14'($urandom);
        lim.dclink_under_volt_limit = 14'($urandom);
        lim.bus_error_limit         = 16'($urandom_range(0, 10));
        lim.bus_warn_min_dclink     = 14'($urandom);
      end
    endcase
  endtask

  task automatic wait_all_results();
    ev_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : status_sink
    logic [15:0] stall_pattern;
    bit          hold_done;
    st_if.ready   = 1'b0;
    hold_done     = 1'b0;
    stall_pattern = 16'($urandom) | 16'h0101;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        // hold the sink off long enough for the block to back up its input
        st_if.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        case (rx_style)
          RX_ALWAYS:  st_if.ready <= 1'b1;
          RX_PATTERN: st_if.ready <= stall_pattern[0];
          default:    st_if.ready <= ($urandom_range(0, 2) != 0);
        endcase
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        if ($urandom_range(0, 63) == 0) stall_pattern = 16'($urandom) | 16'h0101;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((ev_if.valid && ev_if.ready) || (st_if.valid && st_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    sup_event_t  e;
    int unsigned phase_sent;
    int unsigned n;
    int unsigned p;
    bit          held;
    ev_if.valid                 = 1'b0;
    ev_if.mode                  = '0;
    ev_if.clear_request         = 1'b0;
    ev_if.dclink_volt_avg       = '0;
    ev_if.cell_current_filtered = '0;
    ev_if.cell_volt_avg         = '0;
    ev_if.cell_volt_now         = '0;
    ev_if.dclink_volt_now       = '0;
    ev_if.boost_running         = 1'b0;
    ev_if.boost_phase           = '0;
    ev_if.bus_last_error        = '0;
    ev_if.inverter_sequence_ok  = 1'b0;
    cfg_if.valid                = 1'b0;
    cfg_if.index                = '0;
    cfg_if.data                 = '0;
    tx_gappy     = 1'b1;
    burst_left   = 0;
    rx_style     = RX_PATTERN;
    hold_off_req = 1'b0;
    held         = 1'b0;
    lim          = cfws_pkg::CfgReset;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Corner events against the reset limits
    send_fields(cfws_pkg::MODE_PWM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_fields(3'(ModeFirstUnused), 1, '1, 16'sh7FFF, '1, '1, '1, 1, 4'hF, 3'd7, 1);
    send_fields(3'(ModeFirstUnused + 1), 1, '1, 16'sh8000, '1, '1, '1, 1, 4'hF, 3'd7, 0);
    send_fields(3'(ModeLast), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(cfws_pkg::MODE_PWM, 0, '1, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_100MS, 0, 0, 0, '1, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_100MS, 1, 0, 0, 0, 0, 0, 1, 0, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 14'd8000, 16'sd5000, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 14'd8001, 16'sh8000, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 0, 16'sd5001, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_100MS, 0, 0, 0, 14'd439, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_100MS, 0, 0, 0, 14'd440, 0, 0, 1, 0, 0, 1);
    send_fields(cfws_pkg::MODE_100MS, 0, 0, 0, 14'd900, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_100MS, 0, 0, 0, 14'd901, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(cfws_pkg::MODE_10MS, 0, 0, 0, 0, 0, 0, 0, 0, 3'd7, 1);
    send_fields(cfws_pkg::MODE_10MS, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0, 1);
    send_fields(cfws_pkg::MODE_10MS, 0, 0, 0, 0, 0, 0, 0, 0, 3'd1, 1);
    send_fields(cfws_pkg::MODE_FAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_1S, 0, '1, 0, 0, 0, 0, 1, cfws_pkg::BoostPhaseBusB, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_fields(cfws_pkg::MODE_1S, 0, 0, 0, 0, '1, '1, 0, 4'hF, 0, 1);
    send_fields(cfws_pkg::MODE_PWM, 1, 0, 0, 0, '1, 0, 0, 0, 0, 1);
    wait_all_results();

    // Random one-second sequences, each closed by a 1 s tick
    for (p = 0; p < RandomPhases; p++) begin
      wait_all_results();
      pick_limits(p);
      load_limits();
      rx_style   = rx_style_e'(p % 3);
      phase_sent = 0;
      while (phase_sent < RandomItems / RandomPhases) begin
        tx_gappy = ($urandom_range(0, 3) != 0);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 30);
        if (p == HoldOffPhase && phase_sent >= 60 && !held) begin
          hold_off_req = 1'b1;
          held         = 1'b1;
          tx_gappy     = 1'b0;
          n            = 30;
        end
        repeat (n) begin
          e = random_event(pick_mode());
          drive_event(e);
          if (e.mode < ModeFirstUnused) phase_sent++;
        end
        drive_event(random_event(cfws_pkg::MODE_1S));
        phase_sent++;
      end
    end

    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> converter_fault_warning_supervisor.f
rtl/cfws_pkg.sv
rtl/cfws_if.sv
rtl/cfws_cfg.sv
rtl/cfws_core.sv
rtl/converter_fault_warning_supervisor.sv
sim/supervisor_status_checker.sv
sim/tb_converter_fault_warning_supervisor.sv
